### rtl/core/dre_pkg.sv
`default_nettype none

package dre_pkg;

  localparam int unsigned SLOTS    = 16;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned IDX_W    = 13;
  localparam int unsigned LEN_W    = 14;
  localparam int unsigned RING_MAX = 8192;
  localparam int unsigned DESC_W   = 7;
  localparam int unsigned DESC_MAX = 64;
  localparam int unsigned BYTES_W  = 11;
  localparam int unsigned PROD_W   = IDX_W + DESC_W;
  localparam int unsigned STEP_W   = $clog2(LEN_W + 1);

  // slot lifecycle
  localparam logic [2:0] PH_EMPTY      = 3'd0;
  localparam logic [2:0] PH_FETCHING   = 3'd1;
  localparam logic [2:0] PH_PREPARED   = 3'd3;
  localparam logic [2:0] PH_PROCESSING = 3'd4;
  localparam logic [2:0] PH_PROCESSED  = 3'd5;
  localparam logic [2:0] PH_WRITING    = 3'd6;
  localparam logic [2:0] PH_WRITTEN    = 3'd7;

  localparam logic [2:0] OP_TAIL       = 3'd0;
  localparam logic [2:0] OP_ENABLE     = 3'd1;
  localparam logic [2:0] OP_FETCH_DONE = 3'd2;
  localparam logic [2:0] OP_PROCESSED  = 3'd3;
  localparam logic [2:0] OP_WB_DONE    = 3'd4;
  localparam logic [2:0] OP_RESET      = 3'd5;

  localparam logic [1:0] KIND_FETCH   = 2'd0;
  localparam logic [1:0] KIND_PROCESS = 2'd1;
  localparam logic [1:0] KIND_WB      = 2'd2;
  localparam logic [1:0] KIND_HEAD    = 2'd3;

  localparam logic [2:0] CFG_RING_BASE   = 3'd0;
  localparam logic [2:0] CFG_RING_LEN    = 3'd1;
  localparam logic [2:0] CFG_DESC_SIZE   = 3'd2;
  localparam logic [2:0] CFG_FETCH_LIMIT = 3'd3;
  localparam logic [2:0] CFG_ACTIVE_LIM  = 3'd4;
  localparam logic [2:0] CFG_WB_LIMIT    = 3'd5;

  typedef struct packed {
    logic [63:0]       ring_base;
    logic [LEN_W-1:0]  len;
    logic [DESC_W-1:0] desc;
    logic [13:0]       fetch_limit;
    logic [4:0]        active_limit;
    logic [13:0]       wb_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [63:0]        addr;
    logic [BYTES_W-1:0] bytes;
    logic [SLOT_W-1:0]  slot;
    logic [IDX_W-1:0]   idx;
    logic [CNT_W-1:0]   cnt;
    logic [IDX_W-1:0]   head;
    logic               last;
  } res_t;

endpackage

`default_nettype wire

### rtl/core/descriptor_ring_window_engine_unit.sv
// Requests: a request is taken only while the engine is idle, so no new one is taken
// until the last is complete, result-side stalls included. A tail write while stopped
// only stores the tail; a running event scans the slots, runs up to three remainder
// passes and writes the slots it claims; writeback completions also retire written slots.
// The one-read, one-write slot memories take a read and an evaluate state per slot.
// Reset: window empty, engine stopped, tail zero, registers at their defaults.
`default_nettype none

module descriptor_ring_window_engine_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  op_i,
  input  wire logic [12:0] tail_i,
  input  wire logic [3:0]  slot_i,
  input  wire logic [4:0]  count_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [63:0]      dma_addr_o,
  output logic [10:0]      dma_bytes_o,
  output logic [3:0]       first_slot_o,
  output logic [12:0]      ring_index_o,
  output logic [4:0]       slot_count_o,
  output logic [12:0]      head_o,
  output logic             last_o
);
  import dre_pkg::*;

  logic [63:0]       ring_base_q;
  logic [13:0]       ring_len_q;
  logic [DESC_W-1:0] desc_size_q;
  logic [13:0]       fetch_limit_q;
  logic [4:0]        active_limit_q;
  logic [13:0]       wb_limit_q;
  cfg_t              cfg;
  res_t              res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_base_q    <= '0;
      ring_len_q     <= 14'd512;
      desc_size_q    <= 7'd16;
      fetch_limit_q  <= 14'd8192;
      active_limit_q <= 5'd16;
      wb_limit_q     <= 14'd8192;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_RING_BASE:   ring_base_q    <= cfg_data_i;
        CFG_RING_LEN:    ring_len_q     <= cfg_data_i[13:0];
        CFG_DESC_SIZE:   desc_size_q    <= cfg_data_i[DESC_W-1:0];
        CFG_FETCH_LIMIT: fetch_limit_q  <= cfg_data_i[13:0];
        CFG_ACTIVE_LIM:  active_limit_q <= cfg_data_i[4:0];
        CFG_WB_LIMIT:    wb_limit_q     <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  // clamp ring length and descriptor size into their usable ranges
  always_comb begin
    cfg.ring_base    = ring_base_q;
    cfg.fetch_limit  = fetch_limit_q;
    cfg.active_limit = active_limit_q;
    cfg.wb_limit     = wb_limit_q;
    if (ring_len_q == '0) begin
      cfg.len = LEN_W'(1);
    end else if (ring_len_q > LEN_W'(RING_MAX)) begin
      cfg.len = LEN_W'(RING_MAX);
    end else begin
      cfg.len = ring_len_q;
    end
    if (desc_size_q == '0) begin
      cfg.desc = DESC_W'(1);
    end else if (desc_size_q > DESC_W'(DESC_MAX)) begin
      cfg.desc = DESC_W'(DESC_MAX);
    end else begin
      cfg.desc = desc_size_q;
    end
  end

  dre_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .tail_i      (tail_i),
    .slot_i      (slot_i),
    .count_i     (count_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (res)
  );

  assign kind_o       = res.kind;
  assign dma_addr_o   = res.addr;
  assign dma_bytes_o  = res.bytes;
  assign first_slot_o = res.slot;
  assign ring_index_o = res.idx;
  assign slot_count_o = res.cnt;
  assign head_o       = res.head;
  assign last_o       = res.last;

endmodule

`default_nettype wire

### rtl/core/dre_ram.sv
`default_nettype none

module dre_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/dre_mod.sv
`default_nettype none

module dre_mod (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        go_i,
  input  wire logic [dre_pkg::LEN_W-1:0]   dividend_i,
  input  wire logic [dre_pkg::LEN_W-1:0]   divisor_i,
  output logic                             done_o,
  output logic      [dre_pkg::IDX_W-1:0]   rem_o
);
  import dre_pkg::*;

  logic [LEN_W-1:0]  rem_q, rem_d;
  logic [LEN_W-1:0]  quo_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q, done_q;
  logic [LEN_W:0]    trial;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    trial = {rem_q, quo_q[LEN_W-1]};
    if (trial >= {1'b0, divisor_i}) begin
      rem_d = LEN_W'(trial - {1'b0, divisor_i});
    end else begin
      rem_d = trial[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(LEN_W);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[LEN_W-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[IDX_W-1:0];

endmodule

`default_nettype wire

### rtl/core/dre_ctrl.sv
`default_nettype none

module dre_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire dre_pkg::cfg_t               cfg_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [2:0]                  op_i,
  input  wire logic [dre_pkg::IDX_W-1:0]   tail_i,
  input  wire logic [dre_pkg::SLOT_W-1:0]  slot_i,
  input  wire logic [dre_pkg::CNT_W-1:0]   count_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output dre_pkg::res_t                    out_o
);
  import dre_pkg::*;

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_C_RD      = 5'd1;
  localparam logic [4:0] S_C_EV      = 5'd2;
  localparam logic [4:0] S_B_RD      = 5'd3;
  localparam logic [4:0] S_B_EV      = 5'd4;
  localparam logic [4:0] S_HEAD_DIV  = 5'd5;
  localparam logic [4:0] S_HEAD_EMIT = 5'd6;
  localparam logic [4:0] S_F_DIV1    = 5'd7;
  localparam logic [4:0] S_F_DIV2    = 5'd8;
  localparam logic [4:0] S_F_CALC    = 5'd9;
  localparam logic [4:0] S_F_WR      = 5'd10;
  localparam logic [4:0] S_F_EMIT    = 5'd11;
  localparam logic [4:0] S_P_RD      = 5'd12;
  localparam logic [4:0] S_P_EV      = 5'd13;
  localparam logic [4:0] S_W_RD      = 5'd14;
  localparam logic [4:0] S_W_EV      = 5'd15;
  localparam logic [4:0] S_W_CALC    = 5'd16;
  localparam logic [4:0] S_W_WR      = 5'd17;
  localparam logic [4:0] S_W_EMIT    = 5'd18;
  localparam logic [4:0] S_FLUSH     = 5'd19;

  logic [4:0]        state_q, state_d;
  logic [2:0]        ev_op_q, ev_op_d;
  logic [SLOT_W-1:0] ev_slot_q, ev_slot_d;
  logic [CNT_W-1:0]  ev_n_q, ev_n_d;
  logic [IDX_W-1:0]  tail_q, tail_d;
  logic              running_q, running_d;
  logic [SLOT_W-1:0] wfs_q, wfs_d;
  logic [IDX_W-1:0]  wfi_q, wfi_d;
  logic [CNT_W-1:0]  wc_q, wc_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  fcnt_q, fcnt_d;
  logic [IDX_W-1:0]  next_q, next_d;
  logic [IDX_W-1:0]  t_q, t_d;
  logic              skip_q, skip_d;
  logic [PROD_W-1:0] prod_q;
  logic [SLOTS-1:0]  vld_q, vld_d;
  logic              rd_vld_q;
  res_t              pend_q, pend_d, out_q, out_d;
  logic              pend_vld_q, pend_vld_d, out_vld_q, out_vld_d;

  logic [SLOT_W-1:0] rd_addr, wr_addr;
  logic              ph_we, rix_we;
  logic [2:0]        ph_wdata, ph_rdata, ph_rd, ph_from, ph_to;
  logic [IDX_W-1:0]  rix_wdata, rix_rdata;
  logic              div_go, div_done;
  logic [LEN_W-1:0]  div_dividend;
  logic [IDX_W-1:0]  div_rem;
  logic              can_push;
  logic [CNT_W-1:0]  n_sat;
  logic [LEN_W-1:0]  f_avail, f_c, f_free, f_room, w_c;
  logic [IDX_W-1:0]  mul_idx;

  dre_ram #(.WIDTH(3), .DEPTH(SLOTS)) u_phase_ram (
    .clk_i   (clk_i),
    .we_i    (ph_we),
    .waddr_i (wr_addr),
    .wdata_i (ph_wdata),
    .raddr_i (rd_addr),
    .rdata_o (ph_rdata)
  );

  dre_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_index_ram (
    .clk_i   (clk_i),
    .we_i    (rix_we),
    .waddr_i (wr_addr),
    .wdata_i (rix_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rix_rdata)
  );

  dre_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (div_go),
    .dividend_i (div_dividend),
    .divisor_i  (cfg_i.len),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign ph_rd      = rd_vld_q ? ph_rdata : PH_EMPTY;
  assign can_push   = !pend_vld_q || !out_vld_q || !out_stall_i;
  assign n_sat      = (count_i > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : count_i;

  assign rd_addr = ((state_q == S_C_RD || state_q == S_C_EV) ? ev_slot_q : wfs_q)
                   + idx_q[SLOT_W-1:0];
  assign wr_addr = (state_q == S_F_WR) ? (wfs_q + wc_q[SLOT_W-1:0] + idx_q[SLOT_W-1:0])
                                       : rd_addr;
  assign rix_wdata = next_q + IDX_W'(idx_q);

  always_comb begin
    case (ev_op_q)
      OP_FETCH_DONE: begin ph_from = PH_FETCHING;   ph_to = PH_PREPARED;  end
      OP_PROCESSED:  begin ph_from = PH_PROCESSING; ph_to = PH_PROCESSED; end
      default:       begin ph_from = PH_WRITING;    ph_to = PH_WRITTEN;   end
    endcase
  end

  // fetch sizing: ring distance, then free slots, active room, limit, ring end
  always_comb begin
    if (t_q >= next_q) begin
      f_avail = LEN_W'(t_q) - LEN_W'(next_q);
    end else begin
      f_avail = LEN_W'(t_q) + cfg_i.len - LEN_W'(next_q);
    end
    f_free = LEN_W'(SLOTS) - LEN_W'(wc_q);
    f_room = (cfg_i.active_limit > wc_q) ? LEN_W'(cfg_i.active_limit - wc_q) : '0;
    f_c = f_avail;
    if (f_free < f_c) f_c = f_free;
    if (f_room < f_c) f_c = f_room;
    if (cfg_i.fetch_limit < f_c) f_c = cfg_i.fetch_limit;
    if (LEN_W'(next_q) + f_c > cfg_i.len) f_c = cfg_i.len - LEN_W'(next_q);
  end

  always_comb begin
    w_c = LEN_W'(idx_q);
    if (cfg_i.wb_limit < w_c) w_c = cfg_i.wb_limit;
    if (LEN_W'(wfi_q) >= cfg_i.len) begin
      w_c = '0;
    end else if (LEN_W'(wfi_q) + w_c > cfg_i.len) begin
      w_c = cfg_i.len - LEN_W'(wfi_q);
    end
  end

  assign mul_idx = (state_q == S_F_CALC || state_q == S_F_WR || state_q == S_F_EMIT)
                   ? next_q : wfi_q;

  always_comb begin
    logic push, start_fetch, after_cpl, bump_done, proc_start, wb_start;
    res_t new_res;

    state_d    = state_q;
    ev_op_d    = ev_op_q;
    ev_slot_d  = ev_slot_q;
    ev_n_d     = ev_n_q;
    tail_d     = tail_q;
    running_d  = running_q;
    wfs_d      = wfs_q;
    wfi_d      = wfi_q;
    wc_d       = wc_q;
    idx_d      = idx_q;
    fcnt_d     = fcnt_q;
    next_d     = next_q;
    t_d        = t_q;
    skip_d     = skip_q;
    vld_d      = vld_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && out_stall_i;
    ph_we      = 1'b0;
    ph_wdata   = PH_EMPTY;
    rix_we     = 1'b0;
    div_go     = 1'b0;
    div_dividend = '0;
    push        = 1'b0;
    start_fetch = 1'b0;
    after_cpl   = 1'b0;
    bump_done   = 1'b0;
    proc_start  = 1'b0;
    wb_start    = 1'b0;
    new_res     = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ev_op_d   = op_i;
          ev_slot_d = slot_i;
          ev_n_d    = (op_i == OP_PROCESSED) ? CNT_W'(1) : n_sat;
          idx_d     = '0;
          case (op_i)
            OP_TAIL: begin
              tail_d = tail_i;
              if (running_q) start_fetch = 1'b1;
            end
            OP_ENABLE: begin
              running_d   = 1'b1;
              start_fetch = 1'b1;
            end
            OP_FETCH_DONE, OP_PROCESSED: begin
              if (op_i == OP_PROCESSED || n_sat != '0) begin
                state_d = S_C_RD;
              end else if (running_q) begin
                start_fetch = 1'b1;
              end
            end
            OP_WB_DONE: begin
              if (running_q) begin
                state_d = (n_sat != '0) ? S_C_RD : S_B_RD;
              end
            end
            OP_RESET: begin
              running_d = 1'b0;
              wfs_d     = '0;
              wfi_d     = '0;
              wc_d      = '0;
              vld_d     = '0;
            end
            default: ;
          endcase
        end
      end
      S_C_RD: state_d = S_C_EV;
      S_C_EV: begin
        if (ph_rd == ph_from) begin
          ph_we    = 1'b1;
          ph_wdata = ph_to;
        end
        idx_d = idx_q + 1'b1;
        if (idx_q + 1'b1 == ev_n_q) begin
          after_cpl = 1'b1;
        end else begin
          state_d = S_C_RD;
        end
      end
      S_B_RD: begin
        if (idx_q == wc_q) bump_done = 1'b1;
        else               state_d = S_B_EV;
      end
      S_B_EV: begin
        if (ph_rd == PH_WRITTEN) begin
          ph_we    = 1'b1;
          ph_wdata = PH_EMPTY;
          idx_d    = idx_q + 1'b1;
          state_d  = S_B_RD;
        end else begin
          bump_done = 1'b1;
        end
      end
      S_HEAD_DIV: begin
        if (div_done) begin
          wfi_d   = div_rem;
          state_d = S_HEAD_EMIT;
        end
      end
      S_HEAD_EMIT: begin
        if (can_push) begin
          push         = 1'b1;
          new_res.kind = KIND_HEAD;
          new_res.head = wfi_q;
          start_fetch  = 1'b1;
        end
      end
      S_F_DIV1: begin
        if (div_done) begin
          next_d       = div_rem;
          div_go       = 1'b1;
          div_dividend = LEN_W'(tail_q);
          state_d      = S_F_DIV2;
        end
      end
      S_F_DIV2: begin
        if (div_done) begin
          t_d     = div_rem;
          state_d = S_F_CALC;
        end
      end
      S_F_CALC: begin
        fcnt_d = f_c[CNT_W-1:0];
        idx_d  = '0;
        if (f_c == '0) proc_start = 1'b1;
        else           state_d = S_F_WR;
      end
      S_F_WR: begin
        ph_we    = 1'b1;
        ph_wdata = PH_FETCHING;
        rix_we   = 1'b1;
        vld_d[wr_addr] = 1'b1;
        idx_d    = idx_q + 1'b1;
        if (idx_q + 1'b1 == fcnt_q) state_d = S_F_EMIT;
      end
      S_F_EMIT: begin
        if (can_push) begin
          push          = 1'b1;
          new_res.kind  = KIND_FETCH;
          new_res.addr  = cfg_i.ring_base + 64'(prod_q);
          new_res.bytes = BYTES_W'(cfg_i.desc) * BYTES_W'(fcnt_q);
          new_res.slot  = wfs_q + wc_q[SLOT_W-1:0];
          new_res.idx   = next_q;
          new_res.cnt   = fcnt_q;
          wc_d          = wc_q + fcnt_q;
          proc_start    = 1'b1;
        end
      end
      S_P_RD: begin
        if (idx_q == wc_q) wb_start = 1'b1;
        else               state_d = S_P_EV;
      end
      S_P_EV: begin
        if (skip_q && ph_rd > PH_PREPARED) begin
          idx_d   = idx_q + 1'b1;
          state_d = S_P_RD;
        end else if (ph_rd == PH_PREPARED) begin
          if (can_push) begin
            ph_we        = 1'b1;
            ph_wdata     = PH_PROCESSING;
            push         = 1'b1;
            new_res.kind = KIND_PROCESS;
            new_res.slot = rd_addr;
            new_res.idx  = rix_rdata;
            idx_d        = idx_q + 1'b1;
            skip_d       = 1'b0;
            state_d      = S_P_RD;
          end
        end else begin
          wb_start = 1'b1;
        end
      end
      S_W_RD: begin
        if (idx_q == wc_q) state_d = S_W_CALC;
        else               state_d = S_W_EV;
      end
      S_W_EV: begin
        if (ph_rd == PH_PROCESSED) begin
          idx_d   = idx_q + 1'b1;
          state_d = S_W_RD;
        end else begin
          state_d = S_W_CALC;
        end
      end
      S_W_CALC: begin
        fcnt_d = w_c[CNT_W-1:0];
        idx_d  = '0;
        state_d = (w_c == '0) ? S_FLUSH : S_W_WR;
      end
      S_W_WR: begin
        ph_we    = 1'b1;
        ph_wdata = PH_WRITING;
        idx_d    = idx_q + 1'b1;
        if (idx_q + 1'b1 == fcnt_q) state_d = S_W_EMIT;
      end
      S_W_EMIT: begin
        if (can_push) begin
          push          = 1'b1;
          new_res.kind  = KIND_WB;
          new_res.addr  = cfg_i.ring_base + 64'(prod_q);
          new_res.bytes = BYTES_W'(cfg_i.desc) * BYTES_W'(fcnt_q);
          new_res.slot  = wfs_q;
          new_res.idx   = wfi_q;
          new_res.cnt   = fcnt_q;
          state_d       = S_FLUSH;
        end
      end
      S_FLUSH: begin
        // release the held result as the final one of this request
        if (!pend_vld_q) begin
          state_d = S_IDLE;
        end else if (!out_vld_q || !out_stall_i) begin
          out_d      = pend_q;
          out_d.last = 1'b1;
          out_vld_d  = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (after_cpl) begin
      if (ev_op_q == OP_WB_DONE) begin
        idx_d   = '0;
        state_d = S_B_RD;
      end else if (running_q) begin
        start_fetch = 1'b1;
      end else begin
        state_d = S_FLUSH;
      end
    end
    if (bump_done) begin
      wfs_d        = wfs_q + idx_q[SLOT_W-1:0];
      wc_d         = wc_q - idx_q;
      div_go       = 1'b1;
      div_dividend = LEN_W'(wfi_q) + LEN_W'(idx_q);
      state_d      = S_HEAD_DIV;
    end
    if (start_fetch) begin
      div_go       = 1'b1;
      div_dividend = LEN_W'(wfi_q) + LEN_W'(wc_q);
      state_d      = S_F_DIV1;
    end
    if (proc_start) begin
      idx_d   = '0;
      skip_d  = 1'b1;
      state_d = S_P_RD;
    end
    if (wb_start) begin
      idx_d   = '0;
      state_d = S_W_RD;
    end
    // hold one result back so the last one can be marked
    if (push) begin
      if (pend_vld_q) begin
        out_d     = pend_q;
        out_vld_d = 1'b1;
      end
      pend_d     = new_res;
      pend_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      tail_q     <= '0;
      running_q  <= 1'b0;
      wfs_q      <= '0;
      wfi_q      <= '0;
      wc_q       <= '0;
      idx_q      <= '0;
      skip_q     <= 1'b0;
      vld_q      <= '0;
      rd_vld_q   <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      tail_q     <= tail_d;
      running_q  <= running_d;
      wfs_q      <= wfs_d;
      wfi_q      <= wfi_d;
      wc_q       <= wc_d;
      idx_q      <= idx_d;
      skip_q     <= skip_d;
      vld_q      <= vld_d;
      rd_vld_q   <= vld_q[rd_addr];
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_op_q   <= ev_op_d;
    ev_slot_q <= ev_slot_d;
    ev_n_q    <= ev_n_d;
    fcnt_q    <= fcnt_d;
    next_q    <= next_d;
    t_q       <= t_d;
    pend_q    <= pend_d;
    out_q     <= out_d;
    prod_q    <= PROD_W'(mul_idx) * PROD_W'(cfg_i.desc);
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

### dv/descriptor_ring_window_engine_checker.sv
module descriptor_ring_window_engine_checker
  import dre_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  op_i,
  input  logic [12:0] tail_i,
  input  logic [3:0]  slot_i,
  input  logic [4:0]  count_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  kind_i,
  input  logic [63:0] dma_addr_i,
  input  logic [10:0] dma_bytes_i,
  input  logic [3:0]  first_slot_i,
  input  logic [12:0] ring_index_i,
  input  logic [4:0]  slot_count_i,
  input  logic [12:0] head_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          waiting_o,
  output int          results_o
);

  cfg_t        regs;
  logic [2:0]  slot_phase [SLOTS];
  logic [12:0] slot_index [SLOTS];
  int unsigned win_slot, win_index, win_count, tail_reg;
  bit          running;
  res_t        expected_q [$];
  res_t        fresh_q [$];

  assign waiting_o = expected_q.size();

  function automatic int unsigned ring_size();
    if (regs.len == 0) return 1;
    if (regs.len > RING_MAX) return RING_MAX;
    return regs.len;
  endfunction

  function automatic int unsigned desc_bytes();
    if (regs.desc == 0) return 1;
    if (regs.desc > DESC_MAX) return DESC_MAX;
    return regs.desc;
  endfunction

  function automatic int unsigned min_u(int unsigned a, int unsigned b);
    return (a < b) ? a : b;
  endfunction

  task automatic add_result(input logic [1:0] kind, input logic [63:0] addr,
                            input int unsigned bytes, input int unsigned slot,
                            input int unsigned idx, input int unsigned cnt,
                            input int unsigned head);
    res_t r;
    r.kind  = kind;
    r.addr  = addr;
    r.bytes = bytes[10:0];
    r.slot  = slot[3:0];
    r.idx   = idx[12:0];
    r.cnt   = cnt[4:0];
    r.head  = head[12:0];
    r.last  = 1'b0;
    fresh_q.push_back(r);
  endtask

  task automatic clear_window();
    running   = 0;
    win_slot  = 0;
    win_index = 0;
    win_count = 0;
    for (int i = 0; i < SLOTS; i++) slot_phase[i] = PH_EMPTY;
  endtask

  task automatic issue_fetch();
    int unsigned len, nxt, c, pos;
    len = ring_size();
    nxt = (win_index + win_count) % len;
    c   = ((tail_reg % len) + len - nxt) % len;
    c   = min_u(c, SLOTS - win_count);
    c   = min_u(c, (regs.active_limit > win_count) ? regs.active_limit - win_count : 0);
    c   = min_u(c, regs.fetch_limit);
    if (nxt + c > len) c = len - nxt;
    if (c == 0) return;
    pos = (win_slot + win_count) % SLOTS;
    for (int unsigned i = 0; i < c; i++) begin
      slot_phase[(pos + i) % SLOTS] = PH_FETCHING;
      slot_index[(pos + i) % SLOTS] = 13'((nxt + i) % len);
    end
    win_count += c;
    add_result(KIND_FETCH, regs.ring_base + 64'(nxt) * 64'(desc_bytes()),
               desc_bytes() * c, pos, nxt, c, 0);
  endtask

  task automatic start_processing();
    int unsigned i, s;
    i = 0;
    while (i < win_count && slot_phase[(win_slot + i) % SLOTS] > PH_PREPARED) i++;
    while (i < win_count) begin
      s = (win_slot + i) % SLOTS;
      if (slot_phase[s] != PH_PREPARED) break;
      slot_phase[s] = PH_PROCESSING;
      add_result(KIND_PROCESS, 64'd0, 0, s, slot_index[s], 0, 0);
      i++;
    end
  endtask

  task automatic issue_writeback();
    int unsigned len, avail, c;
    len   = ring_size();
    avail = 0;
    while (avail < win_count && slot_phase[(win_slot + avail) % SLOTS] == PH_PROCESSED)
      avail++;
    c = min_u(avail, regs.wb_limit);
    if (win_index >= len) c = 0;
    else if (win_index + c > len) c = len - win_index;
    if (c == 0) return;
    for (int unsigned i = 0; i < c; i++) slot_phase[(win_slot + i) % SLOTS] = PH_WRITING;
    add_result(KIND_WB, regs.ring_base + 64'(win_index) * 64'(desc_bytes()),
               desc_bytes() * c, win_slot, win_index, c, 0);
  endtask

  task automatic predict_event(input logic [2:0] op, input logic [12:0] tl,
                               input logic [3:0] sl, input logic [4:0] ct);
    int unsigned c, s, bump;
    res_t r;
    fresh_q.delete();
    c = (ct > SLOTS) ? SLOTS : ct;
    case (op)
      OP_TAIL:   tail_reg = tl;
      OP_ENABLE: running = 1;
      OP_FETCH_DONE:
        for (int unsigned i = 0; i < c; i++) begin
          s = (sl + i) % SLOTS;
          if (slot_phase[s] == PH_FETCHING) slot_phase[s] = PH_PREPARED;
        end
      OP_PROCESSED:
        if (slot_phase[sl] == PH_PROCESSING) slot_phase[sl] = PH_PROCESSED;
      OP_WB_DONE:
        if (running) begin
          for (int unsigned i = 0; i < c; i++) begin
            s = (sl + i) % SLOTS;
            if (slot_phase[s] == PH_WRITING) slot_phase[s] = PH_WRITTEN;
          end
          bump = 0;
          while (bump < win_count && slot_phase[(win_slot + bump) % SLOTS] == PH_WRITTEN) begin
            slot_phase[(win_slot + bump) % SLOTS] = PH_EMPTY;
            bump++;
          end
          win_slot  = (win_slot + bump) % SLOTS;
          win_index = (win_index + bump) % ring_size();
          win_count -= bump;
          add_result(KIND_HEAD, 64'd0, 0, 0, 0, 0, win_index);
        end
      OP_RESET: begin
        clear_window();
        return;
      end
      default: return;
    endcase
    if (running) begin
      issue_fetch();
      start_processing();
      issue_writeback();
    end
    foreach (fresh_q[k]) begin
      r = fresh_q[k];
      r.last = (k == fresh_q.size() - 1);
      expected_q.push_back(r);
    end
  endtask

  function automatic int field_bad(input string name, input logic [63:0] exp_v,
                                   input logic [63:0] act_v);
    if (exp_v === act_v) return 0;
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    int   bad;
    if (!rst_ni) begin
      regs.ring_base    = '0;
      regs.len          = 512;
      regs.desc         = 16;
      regs.fetch_limit  = 8192;
      regs.active_limit = 16;
      regs.wb_limit     = 8192;
      clear_window();
      for (int i = 0; i < SLOTS; i++) slot_index[i] = '0;
      tail_reg = 0;
      expected_q.delete();
      fail_count_o <= 0;
      results_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        results_o <= results_o + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected, kind %0d", $time, kind_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          bad  = field_bad("kind", want.kind, kind_i)
               + field_bad("dma_addr", want.addr, dma_addr_i)
               + field_bad("dma_bytes", want.bytes, dma_bytes_i)
               + field_bad("first_slot", want.slot, first_slot_i)
               + field_bad("ring_index", want.idx, ring_index_i)
               + field_bad("slot_count", want.cnt, slot_count_i)
               + field_bad("head", want.head, head_i)
               + field_bad("last", want.last, last_i);
          if (bad != 0) fail_count_o <= fail_count_o + 1;
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_RING_BASE:   regs.ring_base    = cfg_data_i;
          CFG_RING_LEN:    regs.len          = cfg_data_i[LEN_W-1:0];
          CFG_DESC_SIZE:   regs.desc         = cfg_data_i[DESC_W-1:0];
          CFG_FETCH_LIMIT: regs.fetch_limit  = cfg_data_i[13:0];
          CFG_ACTIVE_LIM:  regs.active_limit = cfg_data_i[4:0];
          CFG_WB_LIMIT:    regs.wb_limit     = cfg_data_i[13:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_event(op_i, tail_i, slot_i, count_i);
    end
  end

endmodule

### dv/descriptor_ring_window_engine_unit_tb.sv
module descriptor_ring_window_engine_unit_tb;
  import dre_pkg::*;

  localparam int SETTLE = 200;
  localparam int STALL_LIMIT = 3000;

  typedef struct {
    logic [3:0] slot;
    logic [4:0] cnt;
  } span_t;

  logic        clk_i, rst_ni;
  logic        cfg_valid_i, cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        in_valid_i, in_stall_o;
  logic [2:0]  op_i;
  logic [12:0] tail_i;
  logic [3:0]  slot_i;
  logic [4:0]  count_i;
  logic        out_valid_o, out_stall_i;
  logic [1:0]  kind_o;
  logic [63:0] dma_addr_o;
  logic [10:0] dma_bytes_o;
  logic [3:0]  first_slot_o;
  logic [12:0] ring_index_o;
  logic [4:0]  slot_count_o;
  logic [12:0] head_o;
  logic        last_o;
  int          fail_count, waiting, results;

  int          tx_pct, rx_pct, items_sent, idle_cycles;
  bit          hold_req;
  int          hold_left;
  int unsigned cur_len, cur_tail;
  span_t       fetch_spans [$];
  span_t       wb_spans [$];
  logic [3:0]  busy_slots [$];

  descriptor_ring_window_engine_unit dut (.*);

  descriptor_ring_window_engine_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .op_i, .tail_i, .slot_i, .count_i,
    .out_valid_i(out_valid_o), .out_stall_i, .kind_i(kind_o), .dma_addr_i(dma_addr_o),
    .dma_bytes_i(dma_bytes_o), .first_slot_i(first_slot_o), .ring_index_i(ring_index_o),
    .slot_count_i(slot_count_o), .head_i(head_o), .last_i(last_o),
    .fail_count_o(fail_count), .waiting_o(waiting), .results_o(results)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random stalls, or a long hold-off on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 0;
      hold_left = 400;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rx_pct);
    end
  end

  // keep track of what the engine asked for so completions can match it
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      case (kind_o)
        KIND_FETCH:   fetch_spans.push_back('{first_slot_o, slot_count_o});
        KIND_PROCESS: busy_slots.push_back(first_slot_o);
        KIND_WB:      wb_spans.push_back('{first_slot_o, slot_count_o});
        default: ;
      endcase
      if (fetch_spans.size() > 32) void'(fetch_spans.pop_front());
      if (busy_slots.size() > 32) void'(busy_slots.pop_front());
      if (wb_spans.size() > 32) void'(wb_spans.pop_front());
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_event(input logic [2:0] op, input logic [12:0] tl,
                            input logic [3:0] sl, input logic [4:0] ct);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < tx_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    op_i       = op;
    tail_i     = tl;
    slot_i     = sl;
    count_i    = ct;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic drain(input int extra);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (waiting != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic configure(input logic [63:0] base, input int unsigned len,
                           input int unsigned desc, input int unsigned fl,
                           input int unsigned al, input int unsigned wbl);
    drain(SETTLE);
    write_reg(CFG_RING_BASE, base);
    write_reg(CFG_RING_LEN, 64'(len));
    write_reg(CFG_DESC_SIZE, 64'(desc));
    write_reg(CFG_FETCH_LIMIT, 64'(fl));
    write_reg(CFG_ACTIVE_LIM, 64'(al));
    write_reg(CFG_WB_LIMIT, 64'(wbl));
    len = len % 16384;
    cur_len = (len == 0) ? 1 : (len > RING_MAX) ? RING_MAX : len;
    cur_tail = 0;
    fetch_spans.delete();
    wb_spans.delete();
    busy_slots.delete();
  endtask

  task automatic random_event();
    int    r, k;
    span_t sp;
    r = $urandom_range(0, 99);
    if (r < 20 && fetch_spans.size() != 0) begin
      sp = fetch_spans.pop_front();
      if ($urandom_range(0, 4) == 0) sp.cnt = 5'($urandom_range(0, 31));
      send_event(OP_FETCH_DONE, 13'($urandom), sp.slot, sp.cnt);
    end else if (r < 45 && busy_slots.size() != 0) begin
      k = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(0, busy_slots.size() - 1);
      send_event(OP_PROCESSED, 13'($urandom), busy_slots[k], 5'($urandom));
      busy_slots.delete(k);
    end else if (r < 62 && wb_spans.size() != 0) begin
      sp = wb_spans.pop_front();
      send_event(OP_WB_DONE, 13'($urandom), sp.slot, sp.cnt);
    end else if (r < 85) begin
      if ($urandom_range(0, 9) == 0) begin
        send_event(OP_TAIL, 13'($urandom), 4'($urandom), 5'($urandom));
      end else begin
        cur_tail = (cur_tail + $urandom_range(0, 12)) % cur_len;
        send_event(OP_TAIL, 13'(cur_tail), 4'($urandom), 5'($urandom));
      end
    end else if (r < 90) begin
      send_event(OP_ENABLE, 13'($urandom), 4'($urandom), 5'($urandom));
    end else if (r < 92) begin
      send_event(OP_RESET, 13'($urandom), 4'($urandom), 5'($urandom));
    end else begin
      send_event(3'($urandom_range(0, 7)), 13'($urandom), 4'($urandom), 5'($urandom));
    end
  endtask

  task automatic run_phase(input int count, input int hold_at, input int pause_at);
    send_event(OP_RESET, '0, '0, '0);
    send_event(OP_ENABLE, '0, '0, '0);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_req = 1;
      if (i == pause_at) drain(0);
      random_event();
    end
  endtask

  initial begin
    span_t sp;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_RING_BASE;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    op_i        = OP_TAIL;
    tail_i      = '0;
    slot_i      = '0;
    count_i     = '0;
    tx_pct      = 32;
    rx_pct      = 52;
    hold_req    = 0;
    hold_left   = 0;
    items_sent  = 0;
    idle_cycles = 0;
    cur_len     = 512;
    cur_tail    = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: stopped engine, full window, out-of-order processing, odd codes
    send_event(OP_WB_DONE, '0, '0, 5'd1);
    send_event(OP_TAIL, 13'h1FFF, '0, '0);
    send_event(OP_ENABLE, '0, '0, '0);
    drain(0);
    send_event(OP_FETCH_DONE, '0, 4'd15, 5'd31);
    drain(0);
    send_event(OP_PROCESSED, '0, 4'd3, '0);
    send_event(OP_PROCESSED, '0, 4'd3, '0);
    send_event(OP_PROCESSED, '0, 4'd0, '0);
    send_event(OP_PROCESSED, '0, 4'd1, '0);
    send_event(OP_PROCESSED, '0, 4'd2, '0);
    send_event(OP_WB_DONE, '0, 4'd9, 5'd16);
    drain(0);
    while (wb_spans.size() != 0) begin
      sp = wb_spans.pop_front();
      send_event(OP_WB_DONE, '0, sp.slot, sp.cnt);
    end
    send_event(3'd6, 13'h1FFF, 4'hF, 5'h1F);
    send_event(3'd7, '0, '0, '0);
    send_event(OP_RESET, '0, '0, '0);
    send_event(OP_TAIL, 13'd0, '0, '0);
    send_event(OP_ENABLE, '0, '0, '0);

    configure(64'hFFFF_FFFF_FFFF_FFF0, 20, 64, 3, 16, 2);
    run_phase(70, 30, -1);
    configure(64'($urandom), 1, 0, 8192, 5, 8192);
    run_phase(70, -1, -1);
    tx_pct = 52;
    rx_pct = 32;
    configure(64'h0, 8192, 127, 16383, 31, 1);
    run_phase(70, -1, -1);
    configure({$urandom, $urandom}, 0, 1, 0, 0, 0);
    run_phase(20, -1, -1);
    tx_pct = 0;
    rx_pct = 0;
    configure({$urandom, $urandom}, 37, 24, 7, 16, 5);
    run_phase(70, -1, 35);
    configure(64'h8000_0000_0000_0000, 16383, 16, 16, 9, 16);
    run_phase(70, -1, -1);
    configure(64'h1000, 50, 8, 4, 12, 3);
    run_phase(60, -1, -1);

    drain(SETTLE);
    $display("tb: %0d events sent over eight register settings, %0d results checked",
             items_sent, results);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/dre_pkg.sv
rtl/core/dre_ram.sv
rtl/core/dre_mod.sv
rtl/core/dre_ctrl.sv
rtl/core/descriptor_ring_window_engine_unit.sv
dv/descriptor_ring_window_engine_checker.sv
dv/descriptor_ring_window_engine_unit_tb.sv
